/* rtl/core/evfw_pkg.sv */
// Shared types, codes and defaults for the event flag waiter unit.
package evfw_pkg;

  localparam int unsigned DepthDefault  = 16;
  localparam int unsigned IdBitsDefault = 8;
  localparam int unsigned CfgIdxBits    = 4;

  typedef enum logic [1:0] {
    OP_WAIT  = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    KIND_PASSED   = 3'd0,
    KIND_QUEUED   = 3'd1,
    KIND_FULL     = 3'd2,
    KIND_RELEASED = 3'd3,
    KIND_SET      = 3'd4,
    KIND_CLEAR    = 3'd5
  } kind_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_AUTO_CLEAR    = 4'd0,
    CFG_INIT_SIGNALED = 4'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_FIN
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic exec;  // execute the accepted request
    logic pop;   // release the front waiter
    logic fin;   // emit the closing set status
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic signaled;
    logic auto_clear;
    logic count_zero;
    logic one_left;
    logic slot_free;
  } status_t;

endpackage

/* rtl/core/evfw_if.sv */
// Channel interfaces: request, response and configuration write.
interface evfw_req_if #(
  parameter int unsigned IdBits = evfw_pkg::IdBitsDefault
);
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [IdBits-1:0] task_id;

  modport source (output valid, operation, task_id, input ready);
  modport sink (input valid, operation, task_id, output ready);
endinterface

interface evfw_rsp_if #(
  parameter int unsigned IdBits = evfw_pkg::IdBitsDefault
);
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic [IdBits-1:0] released_task;
  logic              success;
  logic              last;

  modport source (output valid, kind, released_task, success, last, input ready);
  modport sink (input valid, kind, released_task, success, last, output ready);
endinterface

interface evfw_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [evfw_pkg::CfgIdxBits-1:0] index;
  logic                            data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/evfw_ctrl.sv */
// Controller: sequences request execution and the waiter release drain.
module evfw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        operation_i,
  input  evfw_pkg::status_t st_i,
  output logic              in_ready_o,
  output evfw_pkg::cmd_t    cmd_o
);
  import evfw_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = st_i.slot_free;
        cmd_o.exec = in_valid_i && st_i.slot_free;
        // a set with waiters and a clear flag goes on to release them (only the front one in auto mode)
        if (cmd_o.exec && operation_i == OP_SET && !st_i.signaled && !st_i.count_zero) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd_o.pop = st_i.slot_free;
        if (cmd_o.pop && (st_i.auto_clear || st_i.one_left)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.fin = st_i.slot_free;
        if (cmd_o.fin) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.exec, cmd_o.pop, cmd_o.fin}))
    else $error("more than one datapath command at once");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && st_i.slot_free) |=> state_q == ST_IDLE)
    else $error("closing status did not return to idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.pop && !st_i.auto_clear && !st_i.one_left) |=> state_q == ST_DRAIN)
    else $error("broadcast left waiters behind");

endmodule

/* rtl/core/evfw_dp.sv */
// Datapath: flag, mode registers, waiter queue memory and response register.
module evfw_dp #(
  parameter int unsigned Depth  = evfw_pkg::DepthDefault,
  parameter int unsigned IdBits = evfw_pkg::IdBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  evfw_pkg::cmd_t                cmd_i,
  input  logic [1:0]                    operation_i,
  input  logic [IdBits-1:0]             task_id_i,
  input  logic                          cfg_we_i,
  input  logic [evfw_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic                          cfg_data_i,
  input  logic                          rsp_ready_i,
  output logic                          rsp_valid_o,
  output evfw_pkg::kind_e               rsp_kind_o,
  output logic [IdBits-1:0]             rsp_task_o,
  output logic                          rsp_success_o,
  output logic                          rsp_last_o,
  output evfw_pkg::status_t             st_o
);
  import evfw_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned SumW = PtrW + 1;

  logic [IdBits-1:0] mem [Depth];
  logic [IdBits-1:0] rd_q;

  logic              auto_q, auto_d;
  logic              init_q, init_d;
  logic              sig_q, sig_d;
  logic [PtrW-1:0]   head_q, head_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  logic              out_valid_q, out_valid_d;
  kind_e             out_kind_q, out_kind_d;
  logic [IdBits-1:0] out_task_q, out_task_d;
  logic              out_ok_q, out_ok_d;
  logic              out_last_q, out_last_d;

  logic              slot_free, load, we, full;
  logic [SumW-1:0]   tail_sum;
  logic [PtrW-1:0]   tail, head_inc, rd_addr;

  assign slot_free = !out_valid_q || rsp_ready_i;
  assign full      = (cnt_q == CntW'(Depth));
  assign tail_sum  = SumW'(head_q) + SumW'(cnt_q);
  assign tail      = (tail_sum >= SumW'(Depth)) ? PtrW'(tail_sum - SumW'(Depth))
                                                : PtrW'(tail_sum);
  assign head_inc  = (head_q == PtrW'(Depth - 1)) ? '0 : head_q + 1'b1;
  // read ahead the next front entry while popping
  assign rd_addr   = cmd_i.pop ? head_inc : head_q;

  always_comb begin
    auto_d     = auto_q;
    init_d     = init_q;
    sig_d      = sig_q;
    head_d     = head_q;
    cnt_d      = cnt_q;
    we         = 1'b0;
    load       = 1'b0;
    out_kind_d = out_kind_q;
    out_task_d = '0;
    out_ok_d   = 1'b0;
    out_last_d = 1'b1;
    if (cfg_we_i && (cfg_index_i == CFG_AUTO_CLEAR || cfg_index_i == CFG_INIT_SIGNALED)) begin
      if (cfg_index_i == CFG_AUTO_CLEAR) begin
        auto_d = cfg_data_i;
      end else begin
        init_d = cfg_data_i;
      end
      sig_d  = (cfg_index_i == CFG_INIT_SIGNALED) ? cfg_data_i : init_q;
      head_d = '0;
      cnt_d  = '0;
    end else if (cmd_i.exec) begin
      unique case (operation_i)
        OP_WAIT: begin
          load = 1'b1;
          if (sig_q) begin
            if (auto_q) begin
              sig_d = 1'b0;
            end
            out_kind_d = KIND_PASSED;
          end else if (!full) begin
            we         = 1'b1;
            cnt_d      = cnt_q + 1'b1;
            out_kind_d = KIND_QUEUED;
          end else begin
            out_kind_d = KIND_FULL;
          end
        end
        OP_SET: begin
          if (sig_q) begin
            load       = 1'b1;
            out_kind_d = KIND_SET;
          end else if (cnt_q == '0) begin
            load       = 1'b1;
            sig_d      = 1'b1;
            out_kind_d = KIND_SET;
            out_ok_d   = 1'b1;
          end else if (!auto_q) begin
            sig_d = 1'b1;
          end
        end
        OP_CLEAR: begin
          load       = 1'b1;
          sig_d      = 1'b0;
          out_kind_d = KIND_CLEAR;
          out_ok_d   = sig_q;
        end
        default: begin
          load = 1'b0;
        end
      endcase
    end else if (cmd_i.pop) begin
      load       = 1'b1;
      head_d     = head_inc;
      cnt_d      = cnt_q - 1'b1;
      out_kind_d = KIND_RELEASED;
      out_task_d = rd_q;
      out_last_d = 1'b0;
    end else if (cmd_i.fin) begin
      load       = 1'b1;
      out_kind_d = KIND_SET;
      out_ok_d   = 1'b1;
    end
    out_valid_d = load || (out_valid_q && !rsp_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_q      <= 1'b0;
      init_q      <= 1'b0;
      sig_q       <= 1'b0;
      head_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      auto_q      <= auto_d;
      init_q      <= init_d;
      sig_q       <= sig_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // response payload, loaded only when a new result enters
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_kind_q <= out_kind_d;
      out_task_q <= out_task_d;
      out_ok_q   <= out_ok_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[tail] <= task_id_i;
    end
    rd_q <= mem[rd_addr];
  end

  assign rsp_valid_o   = out_valid_q;
  assign rsp_kind_o    = out_kind_q;
  assign rsp_task_o    = out_task_q;
  assign rsp_success_o = out_ok_q;
  assign rsp_last_o    = out_last_q;

  assign st_o.signaled   = sig_q;
  assign st_o.auto_clear = auto_q;
  assign st_o.count_zero = (cnt_q == '0);
  assign st_o.one_left   = (cnt_q == CntW'(1));
  assign st_o.slot_free  = slot_free;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("waiter count beyond queue depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> cnt_q != '0)
    else $error("release from an empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec || cmd_i.pop || cmd_i.fin) |-> slot_free)
    else $error("result overwrote a pending response");

endmodule

/* rtl/core/event_flag_waiter_unit.sv */
// Top level of the event flag waiter unit: controller plus datapath.
//
//  channel | dir | payload                                   | handshake
//  req_i   | in  | operation[1:0], task_id[IdBits-1:0]       | valid/ready
//  rsp_o   | out | kind[2:0], released_task, success, last   | valid/ready
//  cfg_i   | in  | index[3:0], data                          | valid/ready, ready tied high
//
// Wait, clear and a set that releases nobody load their response when taken; a request is taken only when
// the response register is empty or its result transfers in the same cycle.
// A releasing set holds off requests until its releases and the closing set status are out:
// all waiters in manual mode, only the front one in auto mode; one release per cycle unless stalled.
// Reset clears flag, mode registers and queue pointers; no clearing pass is run.
// A stalled response holds the drain in place without losing the read-ahead entry.
module event_flag_waiter_unit #(
  parameter int unsigned WaiterDepth = evfw_pkg::DepthDefault,
  parameter int unsigned TaskIdBits  = evfw_pkg::IdBitsDefault
) (
  input logic         clk_i,
  input logic         rst_ni,
  evfw_req_if.sink    req_i,
  evfw_rsp_if.source  rsp_o,
  evfw_cfg_if.sink    cfg_i
);
  import evfw_pkg::*;

  cmd_t    cmd;
  status_t st;
  kind_e   kind;
  logic    in_ready;

  evfw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .operation_i (req_i.operation),
    .st_i        (st),
    .in_ready_o  (in_ready),
    .cmd_o       (cmd)
  );

  evfw_dp #(
    .Depth  (WaiterDepth),
    .IdBits (TaskIdBits)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .operation_i   (req_i.operation),
    .task_id_i     (req_i.task_id),
    .cfg_we_i      (cfg_i.valid),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_kind_o    (kind),
    .rsp_task_o    (rsp_o.released_task),
    .rsp_success_o (rsp_o.success),
    .rsp_last_o    (rsp_o.last),
    .st_o          (st)
  );

  assign req_i.ready = in_ready;
  assign rsp_o.kind  = kind;
  assign cfg_i.ready = 1'b1;

endmodule
